/* rtl/core/chained_hash_key_table_defines.svh */
// ----------------------------------------------------------------------------
// chained hash key table assertion macros
// clocked assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_KEY_TABLE_DEFINES_SVH
`define CHAINED_HASH_KEY_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CHKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHKT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHKT_ASSERT(lbl, prop, msg)
`define CHKT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/core/chkt_pkg.sv */
// ----------------------------------------------------------------------------
// chkt_pkg
// shared widths, command and status codes and controller states
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chkt_pkg;

  localparam int KEY_W     = 31;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int BUCKET_W  = 4;
  localparam int SLOT_W    = KEY_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_UPDATE
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/chkt_if.sv */
// ----------------------------------------------------------------------------
// chkt_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface chkt_in_if import chkt_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface chkt_out_if import chkt_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BUCKET_W-1:0] bucket;

  modport source (output valid, output status, output bucket, input ready);
  modport sink   (input valid, input status, input bucket, output ready);
endinterface

`default_nettype wire

/* rtl/core/chkt_ram.sv */
// ----------------------------------------------------------------------------
// chkt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chkt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/chkt_mod.sv */
// ----------------------------------------------------------------------------
// chkt_mod
// key modulo bucket count by reciprocal multiplication, then a registered remainder step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_key_table_defines.svh"

module chkt_mod
  import chkt_pkg::*;
#(
  parameter int NUM_BUCKETS = 11
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [KEY_W-1:0]               key,
  output logic                                done,
  output logic      [$clog2(NUM_BUCKETS)-1:0] rem
);

  localparam int REM_W  = $clog2(NUM_BUCKETS);
  localparam int SHIFT  = KEY_W + REM_W;
  localparam int PROD_W = 2 * KEY_W + 1;
  localparam logic [63:0] SCALE      = 64'd1 << SHIFT;
  localparam logic [63:0] RECIP_FULL = (SCALE + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [KEY_W:0] RECIP   = RECIP_FULL[KEY_W:0];
  localparam logic [REM_W-1:0] MOD_LO = REM_W'(NUM_BUCKETS);
  localparam logic [REM_W:0] MODULUS  = (REM_W + 1)'(NUM_BUCKETS);

  logic [PROD_W-1:0] prod;
  logic [REM_W-1:0]  qd;
  logic [REM_W-1:0]  q_lo_r;
  logic [REM_W-1:0]  key_lo_r;
  logic [REM_W-1:0]  rem_r;
  logic              stage_r;
  logic              done_r;

  // quotient is exact for every key below 2**KEY_W
  assign prod = PROD_W'(key) * PROD_W'(RECIP);

  // only the low remainder bits of key - quotient * modulus are needed
  assign qd = q_lo_r * MOD_LO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= start;
      done_r  <= stage_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_lo_r   <= prod[SHIFT +: REM_W];
      key_lo_r <= key[REM_W-1:0];
    end
    if (stage_r) begin
      rem_r <= key_lo_r - qd;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  `CHKT_ASSERT(a_rem_range, done_r |-> ({1'b0, rem_r} < MODULUS), "remainder out of range")
  `CHKT_ASSERT(a_done_after_stage, done_r |-> $past(stage_r), "done without a reduction")
  `CHKT_ASSERT(a_no_restart, stage_r |-> !start, "reduction restarted while busy")

endmodule

`default_nettype wire

/* rtl/core/chained_hash_key_table.sv */
// ----------------------------------------------------------------------------
// chained_hash_key_table
// keyed set hashed by key modulo bucket count, one ram row of slots per bucket
//
//   channel  dir  handshake           payload
//   in_ch    in   valid/ready         cmd[1:0], key[30:0]
//   out_ch   out  valid/ready         status[1:0], bucket[3:0]
//
// a new item is accepted only in idle, after the last one is written back; the
// modulo unit registers the quotient bits of the product with a reciprocal and
// then forms the remainder, then the bucket row is read through the registered
// ram port and the update state compares all slots and writes the row back.
// after reset the ram is swept one row a cycle, clearing every bucket row,
// before the first item is taken.
// a result waits in the output register while the next item is taken; the
// write back stalls only if that register is still full and not being read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_key_table_defines.svh"

module chained_hash_key_table
  import chkt_pkg::*;
#(
  parameter int NUM_BUCKETS      = 11,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  chkt_in_if.sink    in_ch,
  chkt_out_if.source out_ch
);

  localparam int ROW_AW = $clog2(NUM_BUCKETS);
  localparam int ROW_DW = SLOTS_PER_BUCKET * SLOT_W;

  state_t              state_r, state_nxt;
  logic [ROW_AW-1:0]   clr_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_W-1:0]    key_r;
  logic [ROW_AW-1:0]   row_r;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [BUCKET_W-1:0] out_bucket_r;

  logic              in_fire;
  logic              out_free;
  logic              clr_last;
  logic              commit;
  logic              mod_done;
  logic [ROW_AW-1:0] mod_rem;

  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [ROW_DW-1:0] ram_wdata;
  logic [ROW_AW-1:0] ram_raddr;
  logic [ROW_DW-1:0] ram_rdata;

  logic [SLOTS_PER_BUCKET-1:0] hit_vec;
  logic [SLOTS_PER_BUCKET-1:0] empty_vec;
  logic [SLOTS_PER_BUCKET-1:0] free_oh;
  logic                        any_hit;
  logic                        any_free;
  logic [ROW_DW-1:0]           upd_row;
  logic                        upd_we;
  status_t                     upd_status;

  chkt_mod #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .key   (in_ch.key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  chkt_ram #(
    .WIDTH (ROW_DW),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign clr_last = (clr_r == ROW_AW'(NUM_BUCKETS - 1));

  // row stays addressed while the item waits, so read data holds
  assign ram_raddr = (state_r == S_HASH) ? mod_rem : row_r;

  // slot match and lowest free slot
  always_comb begin
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      empty_vec[s] = !ram_rdata[s*SLOT_W + KEY_W];
      hit_vec[s]   = !empty_vec[s] && (ram_rdata[s*SLOT_W +: KEY_W] == key_r);
    end
    free_oh  = empty_vec & (~empty_vec + 1'b1);
    any_hit  = |hit_vec;
    any_free = |empty_vec;
  end

  always_comb begin
    upd_row    = ram_rdata;
    upd_we     = 1'b0;
    upd_status = ST_MISS;
    case (cmd_r)
      CMD_INSERT: begin
        if (any_hit) begin
          upd_status = ST_DUP;
        end else if (any_free) begin
          upd_status = ST_OK;
          upd_we     = 1'b1;
          for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            if (free_oh[s]) begin
              upd_row[s*SLOT_W +: SLOT_W] = {1'b1, key_r};
            end
          end
        end else begin
          upd_status = ST_FULL;
        end
      end
      CMD_SEARCH: begin
        upd_status = any_hit ? ST_OK : ST_MISS;
      end
      CMD_DELETE: begin
        if (any_hit) begin
          upd_status = ST_OK;
          upd_we     = 1'b1;
          for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            if (hit_vec[s]) begin
              upd_row[s*SLOT_W +: SLOT_W] = '0;
            end
          end
        end
      end
      default: begin
        upd_status = ST_MISS;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_fire) state_nxt = S_HASH;
      S_HASH:   if (mod_done) state_nxt = S_UPDATE;
      S_UPDATE: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ch.ready = 1'b0;
    commit      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = row_r;
    ram_wdata   = upd_row;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      S_HASH: begin
        ram_we = 1'b0;
      end
      S_UPDATE: begin
        commit = out_free;
        ram_we = out_free && upd_we;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_ch.cmd;
      key_r <= in_ch.key;
    end
    if (state_r == S_HASH && mod_done) begin
      row_r <= mod_rem;
    end
    if (commit) begin
      out_status_r <= upd_status;
      out_bucket_r <= BUCKET_W'(row_r);
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.bucket = out_bucket_r;

  `CHKT_ASSERT(a_result_from_update, $rose(out_valid_r) |-> $past(state_r == S_UPDATE),
               "result raised outside write back")
  `CHKT_ASSERT(a_write_when_owned, ram_we |-> (state_r == S_CLEAR || state_r == S_UPDATE),
               "ram written outside clear or write back")
  `CHKT_ASSERT(a_hash_in_time, mod_done |-> (state_r == S_HASH), "modulo done while not hashing")
  `CHKT_ASSERT(a_hold_on_stall,
               (state_r == S_UPDATE && out_valid_r && !out_ch.ready) |=> (state_r == S_UPDATE),
               "pending result overwritten")
  `CHKT_ASSERT_RST(a_reset_clears, !rst_n |=> (state_r == S_CLEAR && !out_valid_r),
                   "reset did not restart the clearing sweep")

endmodule

`default_nettype wire
